// File: rtl/core/mde_pkg.sv
package mde_pkg;

    // output queue between classifier and serialiser
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // held lead character codes
    localparam logic [2:0] LEAD_IDLE  = 3'd0;
    localparam logic [2:0] LEAD_LT    = 3'd1;
    localparam logic [2:0] LEAD_GT    = 3'd2;
    localparam logic [2:0] LEAD_EQ    = 3'd3;
    localparam logic [2:0] LEAD_MINUS = 3'd4;
    localparam logic [2:0] LEAD_EXCL  = 3'd5;
    localparam logic [2:0] LEAD_COL   = 3'd6;

    // command opcodes handed to the serialiser
    localparam logic [2:0] OP_PASS       = 3'd0;
    localparam logic [2:0] OP_ESC        = 3'd1;
    localparam logic [2:0] OP_FLUSH      = 3'd2;
    localparam logic [2:0] OP_FLUSH_BYTE = 3'd3;
    localparam logic [2:0] OP_ENT        = 3'd4;

    // entity indexes
    localparam logic [3:0] ENT_LT_EQ   = 4'd0;
    localparam logic [3:0] ENT_LT_MIN  = 4'd1;
    localparam logic [3:0] ENT_LT_LT   = 4'd2;
    localparam logic [3:0] ENT_GT_EQ   = 4'd3;
    localparam logic [3:0] ENT_GT_GT   = 4'd4;
    localparam logic [3:0] ENT_EQ_GT   = 4'd5;
    localparam logic [3:0] ENT_EQ_EQ   = 4'd6;
    localparam logic [3:0] ENT_MIN_GT  = 4'd7;
    localparam logic [3:0] ENT_EXCL_EQ = 4'd8;
    localparam logic [3:0] ENT_COL_COL = 4'd9;
    localparam logic [3:0] ENT_COL_EQ  = 4'd10;

    // characters
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TICK  = 8'h60;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_COL   = 8'h3A;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] ent;
        logic [2:0] lead;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    function automatic logic [2:0] lead_code(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            CH_LT:    r = LEAD_LT;
            CH_GT:    r = LEAD_GT;
            CH_EQ:    r = LEAD_EQ;
            CH_MINUS: r = LEAD_MINUS;
            CH_EXCL:  r = LEAD_EXCL;
            CH_COL:   r = LEAD_COL;
            default:  r = LEAD_IDLE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] lead_char(input logic [2:0] lead);
        logic [7:0] r;
        unique case (lead)
            LEAD_LT:    r = CH_LT;
            LEAD_GT:    r = CH_GT;
            LEAD_EQ:    r = CH_EQ;
            LEAD_MINUS: r = CH_MINUS;
            LEAD_EXCL:  r = CH_EXCL;
            LEAD_COL:   r = CH_COL;
            default:    r = CH_LT;
        endcase
        return r;
    endfunction

    // leads whose flush carries a backslash
    function automatic logic lead_esc(input logic [2:0] lead);
        return (lead == LEAD_GT) || (lead == LEAD_EXCL);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return (c == CH_BSL) || (c == CH_TICK) || (c == CH_STAR) || (c == CH_LBRC) ||
               (c == CH_RBRC) || (c == CH_LBRK) || (c == CH_RBRK);
    endfunction

    // returns {hit, entity index}
    function automatic logic [4:0] digraph(input logic [2:0] lead, input logic [7:0] c);
        logic [4:0] r;
        r = {1'b0, ENT_LT_EQ};
        unique case (lead)
            LEAD_LT: begin
                if (c == CH_EQ) r = {1'b1, ENT_LT_EQ};
                else if (c == CH_MINUS) r = {1'b1, ENT_LT_MIN};
                else if (c == CH_LT) r = {1'b1, ENT_LT_LT};
            end
            LEAD_GT: begin
                if (c == CH_EQ) r = {1'b1, ENT_GT_EQ};
                else if (c == CH_GT) r = {1'b1, ENT_GT_GT};
            end
            LEAD_EQ: begin
                if (c == CH_GT) r = {1'b1, ENT_EQ_GT};
                else if (c == CH_EQ) r = {1'b1, ENT_EQ_EQ};
            end
            LEAD_MINUS: begin
                if (c == CH_GT) r = {1'b1, ENT_MIN_GT};
            end
            LEAD_EXCL: begin
                if (c == CH_EQ) r = {1'b1, ENT_EXCL_EQ};
            end
            LEAD_COL: begin
                if (c == CH_COL) r = {1'b1, ENT_COL_COL};
                else if (c == CH_EQ) r = {1'b1, ENT_COL_EQ};
            end
            default: r = {1'b0, ENT_LT_EQ};
        endcase
        return r;
    endfunction

    // entity text, first character in the top byte
    function automatic logic [63:0] ent_text(input logic [3:0] ent);
        logic [63:0] r;
        unique case (ent)
            ENT_LT_EQ:   r = {"&#8804;", 8'h00};
            ENT_LT_MIN:  r = "&#10229;";
            ENT_LT_LT:   r = {"&#8810;", 8'h00};
            ENT_GT_EQ:   r = {"&#8805;", 8'h00};
            ENT_GT_GT:   r = {"&#8811;", 8'h00};
            ENT_EQ_GT:   r = "&#10233;";
            ENT_EQ_EQ:   r = {"&#8801;", 8'h00};
            ENT_MIN_GT:  r = "&#10230;";
            ENT_EXCL_EQ: r = {"&#8800;", 8'h00};
            ENT_COL_COL: r = {"&#8759;", 8'h00};
            ENT_COL_EQ:  r = {"&#8788;", 8'h00};
            default:     r = 64'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] ent_len(input logic [3:0] ent);
        logic [3:0] r;
        if ((ent == ENT_LT_MIN) || (ent == ENT_EQ_GT) || (ent == ENT_MIN_GT)) r = 4'd8;
        else r = 4'd7;
        return r;
    endfunction

    // number of output bytes of a command
    function automatic logic [3:0] cmd_len(input t_cmd cmd);
        logic [3:0] r;
        unique case (cmd.op)
            OP_PASS:       r = 4'd1;
            OP_ESC:        r = 4'd2;
            OP_FLUSH:      r = lead_esc(cmd.lead) ? 4'd2 : 4'd1;
            OP_FLUSH_BYTE: r = lead_esc(cmd.lead) ? 4'd3 : 4'd2;
            OP_ENT:        r = ent_len(cmd.ent);
            default:       r = 4'd1;
        endcase
        return r;
    endfunction

    // byte at position idx of a command
    function automatic logic [7:0] cmd_byte(input t_cmd cmd, input logic [2:0] idx);
        logic [7:0]  r;
        logic [63:0] txt;
        logic        esc;
        esc = lead_esc(cmd.lead);
        txt = ent_text(cmd.ent) << {idx, 3'b000};
        unique case (cmd.op)
            OP_PASS: r = cmd.data;
            OP_ESC:  r = (idx == 3'd0) ? CH_BSL : cmd.data;
            OP_FLUSH: begin
                if (esc && (idx == 3'd0)) r = CH_BSL;
                else r = lead_char(cmd.lead);
            end
            OP_FLUSH_BYTE: begin
                if (esc) begin
                    if (idx == 3'd0) r = CH_BSL;
                    else if (idx == 3'd1) r = lead_char(cmd.lead);
                    else r = cmd.data;
                end else begin
                    r = (idx == 3'd0) ? lead_char(cmd.lead) : cmd.data;
                end
            end
            OP_ENT:  r = txt[63:56];
            default: r = cmd.data;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/mde_front.sv
module mde_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output mde_pkg::t_cmd    o_cmd,
    output logic             o_held
);

    logic [2:0]    r_lead;
    logic [2:0]    n_lead;
    logic          w_emit;
    logic [4:0]    w_dg;
    logic [2:0]    w_lc;
    mde_pkg::t_cmd w_cmd;

    assign o_ready = !i_q_full;
    assign o_held  = (r_lead != mde_pkg::LEAD_IDLE);

    // classify the incoming byte against the held lead
    always_comb begin
        w_dg        = mde_pkg::digraph(r_lead, i_byte);
        w_lc        = mde_pkg::lead_code(i_byte);
        w_cmd.op    = mde_pkg::OP_PASS;
        w_cmd.ent   = w_dg[3:0];
        w_cmd.lead  = r_lead;
        w_cmd.data  = i_byte;
        w_cmd.last  = i_last;
        w_emit      = 1'b1;
        n_lead      = mde_pkg::LEAD_IDLE;
        if ((r_lead >= mde_pkg::LEAD_LT) && (r_lead <= mde_pkg::LEAD_COL)) begin
            w_cmd.op = w_dg[4] ? mde_pkg::OP_ENT : mde_pkg::OP_FLUSH_BYTE;
        end else if (w_lc != mde_pkg::LEAD_IDLE) begin
            w_cmd.lead = w_lc;
            w_cmd.op   = mde_pkg::OP_FLUSH;
            if (!i_last) begin
                w_emit = 1'b0;
                n_lead = w_lc;
            end
        end else if (mde_pkg::is_special(i_byte)) begin
            w_cmd.op = mde_pkg::OP_ESC;
        end
    end

    assign o_push = i_valid && o_ready && w_emit;
    assign o_cmd  = w_cmd;

    // pending lead register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= mde_pkg::LEAD_IDLE;
        end else if (i_valid && o_ready) begin
            r_lead <= n_lead;
        end
    end

endmodule

// File: rtl/core/mde_queue.sv
module mde_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mde_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output mde_pkg::t_cmd    o_cmd
);

    mde_pkg::t_cmd               r_mem [mde_pkg::Q_DEPTH];
    logic [mde_pkg::Q_AW-1:0]    r_wp;
    logic [mde_pkg::Q_AW-1:0]    r_rp;
    logic [mde_pkg::Q_AW:0]      r_cnt;

    assign o_full  = (r_cnt == (mde_pkg::Q_AW + 1)'(mde_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// File: rtl/core/mde_back.sv
module mde_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  mde_pkg::t_cmd    i_q_cmd,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_text_end
);

    mde_pkg::t_cmd r_cmd;
    logic [2:0]    r_idx;
    logic          r_busy;
    logic [3:0]    w_len;
    logic          w_end;
    logic          w_take;

    // position within the current command
    always_comb begin
        w_len  = mde_pkg::cmd_len(r_cmd);
        w_end  = ({1'b0, r_idx} == (w_len - 4'd1));
        w_take = !r_busy || (i_out_ready && w_end);
    end

    assign o_pop       = w_take && i_q_valid;
    assign o_out_valid = r_busy;
    assign o_out_byte  = mde_pkg::cmd_byte(r_cmd, r_idx);
    assign o_run_last  = w_end;
    assign o_text_end  = w_end && r_cmd.last;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_busy <= i_q_valid;
        end
    end

    // command and byte index
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
            r_idx <= '0;
        end else if (r_busy && i_out_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// File: rtl/core/markdown_digraph_escaper.sv
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_in_byte, i_is_last
// output  | out       | o_out_valid / i_out_ready | o_out_byte, o_run_last, o_text_end
//
// one byte accepted per cycle while the command queue has room; the serialiser
// sends one output byte per cycle while the output is ready
// first output byte of an item is registered in the command queue, then in the serialiser
// synchronous active-low reset clears the held lead, the queue and the output valid
// a stalled output fills the four-entry command queue, after which input ready drops
module markdown_digraph_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_q_valid;
    logic          w_held;
    mde_pkg::t_cmd w_f_cmd;
    mde_pkg::t_cmd w_q_cmd;

    // classifier with held lead state
    mde_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_in_byte),
        .i_last   (i_is_last),
        .i_q_full (w_full),
        .o_ready  (o_in_ready),
        .o_push   (w_push),
        .o_cmd    (w_f_cmd),
        .o_held   (w_held)
    );

    // command queue
    mde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_f_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // byte serialiser
    mde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_end  (o_text_end)
    );

`ifndef SYNTH
    // a run keeps going after a transfer that was not its last byte
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> o_out_valid)
        else $error("output run broken before its last byte");

    // end of text only on the last byte of a run
    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_end) |-> o_run_last)
        else $error("text end outside last byte of run");

    // nothing stays held after the final character of a text
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_last) |=> !w_held)
        else $error("lead still held after end of text");
`endif

endmodule

// File: tb/escape_checker.sv
module escape_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    input  logic       i_text_end,
    input  logic       i_drained,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_out,
    output int         o_entities,
    output int         o_texts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       text_end;
    } t_out_char;

    // predicted escaped characters, oldest first
    t_out_char  escaped_fifo[$];
    logic [7:0] step_bytes[$];
    logic [2:0] held_lead = mde_pkg::LEAD_IDLE;
    t_out_char  want;
    bit         leftover_checked = 1'b0;
    int         fail_count = 0;
    int         chars_out = 0;
    int         entities = 0;
    int         texts = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_chars_out  = 0;
        o_entities   = 0;
        o_texts      = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP) $display("tb: mismatch: %s", what);
        fail_count++;
    endtask

    function automatic logic [2:0] lead_of(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            mde_pkg::CH_LT:    r = mde_pkg::LEAD_LT;
            mde_pkg::CH_GT:    r = mde_pkg::LEAD_GT;
            mde_pkg::CH_EQ:    r = mde_pkg::LEAD_EQ;
            mde_pkg::CH_MINUS: r = mde_pkg::LEAD_MINUS;
            mde_pkg::CH_EXCL:  r = mde_pkg::LEAD_EXCL;
            mde_pkg::CH_COL:   r = mde_pkg::LEAD_COL;
            default:           r = mde_pkg::LEAD_IDLE;
        endcase
        return r;
    endfunction

    // entity for a held lead and the next byte, empty when the pair is no digraph
    function automatic string entity_of(input logic [2:0] lead, input logic [7:0] c);
        string s;
        s = "";
        case (lead)
            mde_pkg::LEAD_LT: begin
                if (c == mde_pkg::CH_EQ) s = "&#8804;";
                else if (c == mde_pkg::CH_MINUS) s = "&#10229;";
                else if (c == mde_pkg::CH_LT) s = "&#8810;";
            end
            mde_pkg::LEAD_GT: begin
                if (c == mde_pkg::CH_EQ) s = "&#8805;";
                else if (c == mde_pkg::CH_GT) s = "&#8811;";
            end
            mde_pkg::LEAD_EQ: begin
                if (c == mde_pkg::CH_GT) s = "&#10233;";
                else if (c == mde_pkg::CH_EQ) s = "&#8801;";
            end
            mde_pkg::LEAD_MINUS: begin
                if (c == mde_pkg::CH_GT) s = "&#10230;";
            end
            mde_pkg::LEAD_EXCL: begin
                if (c == mde_pkg::CH_EQ) s = "&#8800;";
            end
            mde_pkg::LEAD_COL: begin
                if (c == mde_pkg::CH_COL) s = "&#8759;";
                else if (c == mde_pkg::CH_EQ) s = "&#8788;";
            end
            default: s = "";
        endcase
        return s;
    endfunction

    // text written when a held lead is given up
    function automatic string flush_text(input logic [2:0] lead);
        string s;
        case (lead)
            mde_pkg::LEAD_LT:    s = "<";
            mde_pkg::LEAD_GT:    s = "\\>";
            mde_pkg::LEAD_EQ:    s = "=";
            mde_pkg::LEAD_MINUS: s = "-";
            mde_pkg::LEAD_EXCL:  s = "\\!";
            mde_pkg::LEAD_COL:   s = ":";
            default:             s = "";
        endcase
        return s;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) step_bytes.push_back(8'(s[i]));
    endfunction

    // escape one accepted character and queue the bytes it produces
    task automatic escape_char(input logic [7:0] c, input logic last);
        logic [2:0] lead;
        string      ent;
        int         n;
        step_bytes.delete();
        lead = held_lead;
        if ((lead >= mde_pkg::LEAD_LT) && (lead <= mde_pkg::LEAD_COL)) begin
            ent = entity_of(lead, c);
            if (ent.len() != 0) begin
                add_text(ent);
                entities++;
            end else begin
                // failed pair: lead as written, then the byte untouched and never held
                add_text(flush_text(lead));
                step_bytes.push_back(c);
            end
            lead = mde_pkg::LEAD_IDLE;
        end else begin
            lead = lead_of(c);
            if (lead == mde_pkg::LEAD_IDLE) begin
                if ((c == mde_pkg::CH_BSL) || (c == mde_pkg::CH_TICK) ||
                    (c == mde_pkg::CH_STAR) || (c == mde_pkg::CH_LBRC) ||
                    (c == mde_pkg::CH_RBRC) || (c == mde_pkg::CH_LBRK) ||
                    (c == mde_pkg::CH_RBRK)) begin
                    step_bytes.push_back(mde_pkg::CH_BSL);
                end
                step_bytes.push_back(c);
            end
        end
        // end of text flushes whatever is still held
        if (last) begin
            add_text(flush_text(lead));
            lead = mde_pkg::LEAD_IDLE;
            texts++;
        end
        held_lead = lead;
        n = (step_bytes.size() > 8) ? 8 : step_bytes.size();
        for (int k = 0; k < n; k++) begin
            escaped_fifo.push_back('{ch: step_bytes[k], run_last: (k == n - 1),
                                     text_end: (k == n - 1) && last});
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_lead = mde_pkg::LEAD_IDLE;
            escaped_fifo.delete();
        end else begin
            // output transfer against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                chars_out++;
                if (escaped_fifo.size() == 0) begin
                    report_mismatch($sformatf("output byte %02h with nothing predicted",
                                              i_out_byte));
                end else begin
                    want = escaped_fifo.pop_front();
                    if (i_out_byte !== want.ch)
                        report_mismatch($sformatf("byte %0d: out_byte %02h, predicted %02h",
                                                  chars_out, i_out_byte, want.ch));
                    if (i_run_last !== want.run_last)
                        report_mismatch($sformatf("byte %0d: run_last %b, predicted %b",
                                                  chars_out, i_run_last, want.run_last));
                    if (i_text_end !== want.text_end)
                        report_mismatch($sformatf("byte %0d: text_end %b, predicted %b",
                                                  chars_out, i_text_end, want.text_end));
                end
            end
            // input transfer
            if (i_in_valid && i_in_ready) escape_char(i_in_byte, i_is_last);
            // anything still predicted once the run has drained
            if (i_drained && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (escaped_fifo.size() != 0)
                    report_mismatch($sformatf("%0d predicted bytes never arrived",
                                              escaped_fifo.size()));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= escaped_fifo.size();
        o_chars_out  <= chars_out;
        o_entities   <= entities;
        o_texts      <= texts;
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 350;
    localparam int DIRECTED     = 25;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 20;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       is_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
    logic       drained   = 1'b0;

    int fail_count;
    int pending;
    int chars_out;
    int entities;
    int texts;
    int cycle_count = 0;
    int chars_sent  = 0;
    bit in_burst    = 1'b0;
    bit out_burst   = 1'b0;

    logic [7:0] lead_chars[6] = '{mde_pkg::CH_LT, mde_pkg::CH_GT, mde_pkg::CH_EQ,
                                  mde_pkg::CH_MINUS, mde_pkg::CH_EXCL, mde_pkg::CH_COL};
    logic [7:0] specials[7]   = '{mde_pkg::CH_BSL, mde_pkg::CH_TICK, mde_pkg::CH_STAR,
                                  mde_pkg::CH_LBRC, mde_pkg::CH_RBRC, mde_pkg::CH_LBRK,
                                  mde_pkg::CH_RBRK};
    // second characters that complete a digraph, per lead
    logic [7:0] partners[6][3] = '{'{mde_pkg::CH_EQ, mde_pkg::CH_MINUS, mde_pkg::CH_LT},
                                   '{mde_pkg::CH_EQ, mde_pkg::CH_GT, mde_pkg::CH_GT},
                                   '{mde_pkg::CH_GT, mde_pkg::CH_EQ, mde_pkg::CH_EQ},
                                   '{mde_pkg::CH_GT, mde_pkg::CH_GT, mde_pkg::CH_GT},
                                   '{mde_pkg::CH_EQ, mde_pkg::CH_EQ, mde_pkg::CH_EQ},
                                   '{mde_pkg::CH_COL, mde_pkg::CH_EQ, mde_pkg::CH_COL}};

    // directed text: extremes, escapes, digraphs, failed pairs, end-of-text flushes
    logic [7:0] dir_chars[DIRECTED] = '{
        8'h00, 8'h80, mde_pkg::CH_BSL, mde_pkg::CH_TICK, mde_pkg::CH_STAR,
        mde_pkg::CH_LBRC, mde_pkg::CH_RBRC, mde_pkg::CH_LBRK, mde_pkg::CH_RBRK,
        mde_pkg::CH_LT, mde_pkg::CH_EQ, mde_pkg::CH_MINUS, mde_pkg::CH_GT,
        mde_pkg::CH_EXCL, mde_pkg::CH_EQ, mde_pkg::CH_COL, mde_pkg::CH_COL,
        mde_pkg::CH_LT, mde_pkg::CH_GT, mde_pkg::CH_GT, 8'h61, mde_pkg::CH_EXCL,
        mde_pkg::CH_EQ, mde_pkg::CH_EQ, 8'hFF};
    logic       dir_last[DIRECTED] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    always #5 clk = ~clk;

    markdown_digraph_escaper u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (in_byte),
        .i_is_last   (is_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_run_last  (run_last),
        .o_text_end  (text_end)
    );

    escape_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_is_last    (is_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_run_last   (run_last),
        .i_text_end   (text_end),
        .i_drained    (drained),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars_out  (chars_out),
        .o_entities   (entities),
        .o_texts      (texts)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: errors");
            $finish;
        end
    end

    // one input transfer after a random gap, valid held until accepted
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        chars_sent++;
    endtask

    // output side holds ready low for a random stall before each transfer, with no stall during a burst
    initial begin : out_side
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int         kind;
        int         li;
        logic [7:0] c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED; i++) send_char(dir_chars[i], dir_last[i]);

        // mostly lead pairs with random content, the rest loose characters
        while (chars_sent < DIRECTED + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                li = $urandom_range(0, 5);
                send_char(lead_chars[li], $urandom_range(0, 15) == 0);
                case ($urandom_range(0, 7))
                    0, 1:    c = 8'($urandom_range(0, 255));
                    2:       c = lead_chars[$urandom_range(0, 5)];
                    default: c = partners[li][$urandom_range(0, 2)];
                endcase
                send_char(c, $urandom_range(0, 7) == 0);
            end else if (kind < 8) begin
                if ($urandom_range(0, 1) == 1) c = specials[$urandom_range(0, 6)];
                else c = lead_chars[$urandom_range(0, 5)];
                send_char(c, $urandom_range(0, 9) == 0);
            end else begin
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
        in_valid <= 1'b0;

        // let the checker count the last transfer before watching the drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        drained <= 1'b1;
        repeat (3) @(posedge clk);

        $display("tb: %0d characters in, %0d escaped bytes out, %0d texts ended",
                 chars_sent, chars_out, texts);
        $display("tb: %0d digraphs turned into entities", entities);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
